// ===== rtl/tct_pkg.sv =====
// Shared types, constants and the arctangent table for the two-circle tangent block.
// Used by tct_cordic and two_circle_common_tangents; depends on nothing else.
package tct_pkg;

  localparam int GUARD     = 16;
  localparam int AW        = 33;
  localparam int SW        = 35;
  localparam int C1W       = 52;
  localparam int C2W       = 34;
  localparam int LW        = 52;
  localparam int DIV_STEPS = 30;
  localparam int SQ_STEPS  = 32;

  localparam logic signed [AW-1:0] PI_Q28    = 33'sd843314857;
  localparam logic signed [31:0]   ANGLE_MAX = 32'sd1686629713;
  localparam logic [31:0]          INV_GAIN  = 32'd2608131496;

  typedef enum logic [1:0] {
    KIND_OUTER  = 2'd0,
    KIND_INNER  = 2'd1,
    KIND_SINGLE = 2'd2
  } kind_t;

  typedef struct packed {
    logic [30:0]           r1;
    logic [30:0]           r2;
    logic signed [AW-1:0]  a;
    logic [LW-1:0]         l;
    logic                  in_pos;
    logic                  in_zero;
    logic                  out_pos;
    logic                  out_zero;
    logic                  l_gt_tol;
  } side_t;

  typedef struct packed {
    logic [LW:0]  rem;
    logic [29:0]  q;
    logic         sat;
    logic         neg;
  } div_t;

  typedef struct packed {
    logic [63:0]         v;
    logic [63:0]         res;
    logic signed [31:0]  q;
  } sq_t;

  function automatic logic signed [AW-1:0] atan_q28(input int idx);
    logic signed [AW-1:0] r;
    case (idx)
      0:  r = 33'sd210828714;
      1:  r = 33'sd124459457;
      2:  r = 33'sd65760959;
      3:  r = 33'sd33381290;
      4:  r = 33'sd16755422;
      5:  r = 33'sd8385879;
      6:  r = 33'sd4193963;
      7:  r = 33'sd2097109;
      8:  r = 33'sd1048571;
      9:  r = 33'sd524287;
      10: r = 33'sd262144;
      11: r = 33'sd131072;
      12: r = 33'sd65536;
      13: r = 33'sd32768;
      14: r = 33'sd16384;
      15: r = 33'sd8192;
      16: r = 33'sd4096;
      17: r = 33'sd2048;
      18: r = 33'sd1024;
      19: r = 33'sd512;
      20: r = 33'sd256;
      21: r = 33'sd128;
      22: r = 33'sd64;
      23: r = 33'sd32;
      24: r = 33'sd16;
      25: r = 33'sd8;
      26: r = 33'sd4;
      27: r = 33'sd2;
      28: r = 33'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/tct_if.sv =====
// Valid/ready channel interfaces for the two-circle tangent block.
// tct_in_if carries one circle pair, tct_out_if carries one tangent angle result.
interface tct_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] first_center_x;
  logic signed [31:0] first_center_y;
  logic [30:0]        first_radius;
  logic signed [31:0] second_center_x;
  logic signed [31:0] second_center_y;
  logic [30:0]        second_radius;

  modport source (output valid, first_center_x, first_center_y, first_radius,
                  second_center_x, second_center_y, second_radius, input ready);
  modport sink (input valid, first_center_x, first_center_y, first_radius,
                second_center_x, second_center_y, second_radius, output ready);
endinterface

interface tct_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] contact_angle;
  logic [1:0]         tangent_kind;
  logic               none_found;
  logic               last_result;

  modport source (output valid, contact_angle, tangent_kind, none_found, last_result,
                  input ready);
  modport sink (input valid, contact_angle, tangent_kind, none_found, last_result,
                output ready);
endinterface

// ===== rtl/tct_cordic.sv =====
// Pipelined vectoring CORDIC, one micro-rotation per register stage.
// Depends on tct_pkg for the arctangent table and the angle format.
module tct_cordic import tct_pkg::*; #(
  parameter int W      = 34,
  parameter int STAGES = 28
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] x_in,
  input  logic signed [W-1:0] y_in,
  output logic signed [W-1:0] mag_out,
  output logic signed [AW-1:0] ang_out
);

  logic signed [W-1:0]  x_r [0:STAGES-1];
  logic signed [W-1:0]  y_r [0:STAGES-1];
  logic signed [AW-1:0] z_r [0:STAGES-1];
  logic signed [W-1:0]  x0, y0;
  logic signed [AW-1:0] z0;

  // A vector in the left half plane is first turned by half a revolution.
  always_comb begin
    if (x_in < 0) begin
      x0 = -x_in;
      y0 = -y_in;
      z0 = (y_in >= 0) ? PI_Q28 : -PI_Q28;
    end else begin
      x0 = x_in;
      y0 = y_in;
      z0 = '0;
    end
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic signed [W-1:0]  xs, ys;
    logic signed [AW-1:0] zs;
    if (k == 0) begin : g_first
      always_comb begin
        xs = x0;
        ys = y0;
        zs = z0;
      end
    end else begin : g_next
      always_comb begin
        xs = x_r[k-1];
        ys = y_r[k-1];
        zs = z_r[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (ys >= 0) begin
          x_r[k] <= xs + (ys >>> k);
          y_r[k] <= ys - (xs >>> k);
          z_r[k] <= zs + atan_q28(k);
        end else begin
          x_r[k] <= xs - (ys >>> k);
          y_r[k] <= ys + (xs >>> k);
          z_r[k] <= zs - atan_q28(k);
        end
      end
    end
  end

  assign mag_out = x_r[STAGES-1];
  assign ang_out = z_r[STAGES-1];

endmodule

// ===== rtl/two_circle_common_tangents.sv =====
// Common tangents of two circles: contact angles on the first circle, fully pipelined.
// Depends on tct_pkg, the tct_in_if and tct_out_if interfaces and tct_cordic.
//
// Usage: in_ch takes one transaction per circle pair (centers signed Q16.16, radii
// unsigned Q15.16). out_ch returns one to four transactions per pair, each with a
// contact angle in Q4.28 radians and its tangent kind; last_result marks the final
// transaction of a pair, and a pair without common tangent gives one transaction with
// none_found set. cfg_we/cfg_wdata write the tolerance used by all sign tests and
// must only be used while no pair is in flight.
// The first result of a pair passes the distance CORDIC, divider, square root and
// angle CORDIC in series, then the output register. A pair may enter every cycle
// unless out_ch stalls; the output register sends one result per cycle while
// out_ch.ready is high; a pair with n results holds the pipeline until all are sent.
// Reset clears all valid bits and the output index and sets the tolerance to 1.
// When out_ch stalls, the whole pipeline holds and in_ch.ready drops, except that
// empty slots still move up behind the waiting result.
module two_circle_common_tangents import tct_pkg::*; #(
  parameter int CORDIC_STAGES = 28
) (
  input  logic        clk,
  input  logic        rst_n,
  tct_in_if.sink      in_ch,
  tct_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int CS    = CORDIC_STAGES;
  localparam int P_MUL = CS + 1;
  localparam int P_L   = CS + 2;
  localparam int P_T   = CS + 3;
  localparam int P_D0  = CS + 4;
  localparam int P_Q   = P_D0 + DIV_STEPS + 1;
  localparam int P_QQ  = P_Q + 1;
  localparam int P_END = P_QQ + SQ_STEPS + CS;

  logic                  en;
  logic [15:0]           tol_r;
  logic                  vld_r  [0:P_END];
  side_t                 side_r [0:P_END];
  side_t                 side_in;
  logic signed [32:0]    dx_r, dy_r;
  logic signed [C1W-1:0] c1_x, c1_y, c1_mag;
  logic signed [AW-1:0]  c1_ang;
  logic [50:0]           um;
  logic [63:0]           lo_full;
  logic [50:0]           hi_r;
  logic [31:0]           lo_r;
  logic [LW-1:0]         l_sum;
  logic [30:0]           dr_l, dr_t;
  logic [46:0]           drs_l, drs_t;
  logic [47:0]           sms_l, sms_t;
  logic signed [53:0]    d_in, d_out, tol_s;
  logic signed [AW-1:0]  c2_ang [0:1];

  // Output assembly and serializer.
  logic signed [31:0]    e_ang  [0:3];
  kind_t                 e_kind [0:3];
  logic [2:0]            e_cnt;
  logic                  e_none;
  logic signed [SW-1:0]  sa, sa1, sa2, single;
  logic                  ser_vld_r;
  logic [1:0]            ser_idx_r;
  logic signed [31:0]    ser_ang_r  [0:3];
  kind_t                 ser_kind_r [0:3];
  logic [2:0]            ser_cnt_r;
  logic                  ser_none_r;
  logic                  is_last;
  logic                  ser_take;

  function automatic logic signed [31:0] clamp_ang(input logic signed [SW-1:0] v);
    logic signed [31:0] r;
    if (v > SW'(ANGLE_MAX)) begin
      r = ANGLE_MAX;
    end else if (v < -SW'(ANGLE_MAX)) begin
      r = -ANGLE_MAX;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= 16'd1;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= P_END; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_ch.valid;
      for (int k = 1; k <= P_END; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_comb begin
    side_in    = '0;
    side_in.r1 = in_ch.first_radius;
    side_in.r2 = in_ch.second_radius;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r      <= 33'(in_ch.second_center_x) - 33'(in_ch.first_center_x);
      dy_r      <= 33'(in_ch.second_center_y) - 33'(in_ch.first_center_y);
      side_r[0] <= side_in;
    end
  end

  assign c1_x = {{(C1W-33-GUARD){dx_r[32]}}, dx_r, {GUARD{1'b0}}};
  assign c1_y = {{(C1W-33-GUARD){dy_r[32]}}, dy_r, {GUARD{1'b0}}};

  tct_cordic #(.W(C1W), .STAGES(CS)) u_cordic_dist (
    .clk     (clk),
    .en      (en),
    .x_in    (c1_x),
    .y_in    (c1_y),
    .mag_out (c1_mag),
    .ang_out (c1_ang)
  );

  // Distance: magnitude times inverse CORDIC gain, from its low 32 and high 19 bits.
  assign um      = c1_mag[C1W-1] ? '0 : c1_mag[50:0];
  assign lo_full = 64'(um[31:0]) * 64'(INV_GAIN);

  always_ff @(posedge clk) begin
    if (en) begin
      hi_r <= 51'(um[50:32]) * 51'(INV_GAIN);
      lo_r <= lo_full[63:32];
    end
  end

  assign l_sum = LW'(hi_r) + LW'(lo_r);

  assign dr_l  = (side_r[P_L].r1 >= side_r[P_L].r2) ? side_r[P_L].r1 - side_r[P_L].r2
                                                     : side_r[P_L].r2 - side_r[P_L].r1;
  assign drs_l = {dr_l, {GUARD{1'b0}}};
  assign sms_l = {32'(side_r[P_L].r1) + 32'(side_r[P_L].r2), {GUARD{1'b0}}};
  assign d_in  = $signed({2'b00, side_r[P_L].l}) - $signed({7'd0, drs_l});
  assign d_out = $signed({2'b00, side_r[P_L].l}) - $signed({6'd0, sms_l});
  assign tol_s = $signed({22'd0, tol_r, {GUARD{1'b0}}});

  for (genvar k = 1; k <= P_END; k++) begin : g_side
    side_t side_nxt;
    always_comb begin
      side_nxt = side_r[k-1];
      if (k == P_MUL) begin
        side_nxt.a = c1_ang;
      end
      if (k == P_L) begin
        side_nxt.l = l_sum;
      end
      if (k == P_T) begin
        side_nxt.in_pos   = d_in > tol_s;
        side_nxt.in_zero  = !(d_in > tol_s) && !(d_in < -tol_s);
        side_nxt.out_pos  = d_out > tol_s;
        side_nxt.out_zero = !(d_out > tol_s) && !(d_out < -tol_s);
        side_nxt.l_gt_tol = side_r[k-1].l > {20'd0, tol_r, {GUARD{1'b0}}};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_nxt;
      end
    end
  end

  assign dr_t  = (side_r[P_T].r1 >= side_r[P_T].r2) ? side_r[P_T].r1 - side_r[P_T].r2
                                                     : side_r[P_T].r2 - side_r[P_T].r1;
  assign drs_t = {dr_t, {GUARD{1'b0}}};
  assign sms_t = {32'(side_r[P_T].r1) + 32'(side_r[P_T].r2), {GUARD{1'b0}}};

  // Lane 0 works on the outer tangents, lane 1 on the inner ones.
  for (genvar ln = 0; ln < 2; ln++) begin : g_lane
    div_t                  div_r [0:DIV_STEPS];
    logic [LW:0]           mag;
    logic [30:0]           qv;
    logic signed [31:0]    q_r, qd_r;
    logic signed [63:0]    prod;
    logic [60:0]           qq_r;
    sq_t                   sq_r [0:SQ_STEPS-1];
    logic signed [C2W-1:0] c2_x, c2_y, c2_mag;

    assign mag = (ln == 0) ? (LW+1)'(drs_t) : (LW+1)'(sms_t);

    always_ff @(posedge clk) begin
      if (en) begin
        div_r[0].rem <= mag;
        div_r[0].q   <= '0;
        div_r[0].sat <= mag >= {1'b0, side_r[P_T].l};
        div_r[0].neg <= (ln == 0) && (side_r[P_T].r1 < side_r[P_T].r2);
      end
    end

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      logic [LW:0] rem2;
      logic        ge;
      assign rem2 = {div_r[j].rem[LW-1:0], 1'b0};
      assign ge   = rem2 >= {1'b0, side_r[P_D0+j].l};
      always_ff @(posedge clk) begin
        if (en) begin
          div_r[j+1].rem <= ge ? rem2 - {1'b0, side_r[P_D0+j].l} : rem2;
          div_r[j+1].q   <= {div_r[j].q[28:0], ge};
          div_r[j+1].sat <= div_r[j].sat;
          div_r[j+1].neg <= div_r[j].neg;
        end
      end
    end

    assign qv   = div_r[DIV_STEPS].sat ? 31'h4000_0000 : {1'b0, div_r[DIV_STEPS].q};
    assign prod = 64'(q_r) * 64'(q_r);

    always_ff @(posedge clk) begin
      if (en) begin
        q_r  <= div_r[DIV_STEPS].neg ? -$signed(32'(qv)) : $signed(32'(qv));
        qq_r <= prod[60:0];
        qd_r <= q_r;
      end
    end

    for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
      sq_t         src;
      logic [63:0] bitv, t;
      if (i == 0) begin : g_first
        always_comb begin
          src.v   = (64'd1 << 60) - 64'(qq_r);
          src.res = '0;
          src.q   = qd_r;
        end
      end else begin : g_next
        always_comb begin
          src = sq_r[i-1];
        end
      end
      assign bitv = 64'd1 << (62 - 2 * i);
      assign t    = src.res + bitv;
      always_ff @(posedge clk) begin
        if (en) begin
          sq_r[i].q <= src.q;
          if (src.v >= t) begin
            sq_r[i].v   <= src.v - t;
            sq_r[i].res <= (src.res >> 1) + bitv;
          end else begin
            sq_r[i].v   <= src.v;
            sq_r[i].res <= src.res >> 1;
          end
        end
      end
    end

    assign c2_y = {{(C2W-31){1'b0}}, sq_r[SQ_STEPS-1].res[30:0]};
    assign c2_x = C2W'(sq_r[SQ_STEPS-1].q);

    tct_cordic #(.W(C2W), .STAGES(CS)) u_cordic_acos (
      .clk     (clk),
      .en      (en),
      .x_in    (c2_x),
      .y_in    (c2_y),
      .mag_out (c2_mag),
      .ang_out (c2_ang[ln])
    );
  end

  assign sa  = SW'(side_r[P_END].a);
  assign sa1 = SW'(c2_ang[0]);
  assign sa2 = SW'(c2_ang[1]);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      e_ang[i]  = '0;
      e_kind[i] = KIND_OUTER;
    end
    e_cnt  = '0;
    e_none = 1'b0;
    single = sa;
    if (side_r[P_END].in_pos) begin
      e_ang[0] = clamp_ang(sa + sa1);
      e_ang[1] = clamp_ang(sa - sa1);
      e_cnt    = 3'd2;
      if (side_r[P_END].out_pos) begin
        e_ang[2]  = clamp_ang(sa + sa2);
        e_ang[3]  = clamp_ang(sa - sa2);
        e_kind[2] = KIND_INNER;
        e_kind[3] = KIND_INNER;
        e_cnt     = 3'd4;
      end
    end
    if ((side_r[P_END].in_zero || side_r[P_END].out_zero) && side_r[P_END].l_gt_tol) begin
      // Internal touching with the first circle the smaller one faces the other way.
      if (side_r[P_END].in_zero && !side_r[P_END].out_zero
          && (side_r[P_END].r1 < side_r[P_END].r2)) begin
        single = sa + SW'(PI_Q28);
      end
      e_ang[e_cnt[1:0]]  = clamp_ang(single);
      e_kind[e_cnt[1:0]] = KIND_SINGLE;
      e_cnt              = e_cnt + 3'd1;
    end
    if (e_cnt == 3'd0) begin
      e_none = 1'b1;
      e_cnt  = 3'd1;
    end
  end

  assign is_last  = ({1'b0, ser_idx_r} + 3'd1) == ser_cnt_r;
  assign ser_take = !ser_vld_r || (out_ch.ready && is_last);
  assign en       = ser_take || !vld_r[P_END];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_vld_r <= 1'b0;
      ser_idx_r <= '0;
    end else if (ser_take) begin
      ser_vld_r <= vld_r[P_END];
      ser_idx_r <= '0;
    end else if (out_ch.ready) begin
      ser_idx_r <= ser_idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_take) begin
      ser_ang_r  <= e_ang;
      ser_kind_r <= e_kind;
      ser_cnt_r  <= e_cnt;
      ser_none_r <= e_none;
    end
  end

  assign in_ch.ready          = en;
  assign out_ch.valid         = ser_vld_r;
  assign out_ch.contact_angle = ser_ang_r[ser_idx_r];
  assign out_ch.tangent_kind  = ser_kind_r[ser_idx_r];
  assign out_ch.none_found    = ser_none_r;
  assign out_ch.last_result   = is_last;

  a_none_is_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.none_found |-> out_ch.last_result && out_ch.contact_angle == 0)
    else $error("none_found result is not a lone zero-angle result");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    ser_vld_r |-> ser_cnt_r != 3'd0 && ser_cnt_r <= 3'd4)
    else $error("result count out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready && vld_r[P_END] |-> !in_ch.ready)
    else $error("pipeline advanced while the output was stalled");

endmodule
